FILE: hdl/mbdcl_pkg.sv
`default_nettype none

package mbdcl_pkg;

  // Field widths of the item ports
  localparam int OPCODE_BITS   = 2;
  localparam int PIN_BITS      = 10;
  localparam int TIME_BITS     = 32;
  localparam int NUMBER_BITS   = 4;
  localparam int MASK_BITS     = 10;
  localparam int DEBOUNCE_BITS = 16;

  // Defaults
  localparam int BUTTON_COUNT_DEFAULT = 10;
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;

  // Operation codes
  localparam logic [OPCODE_BITS-1:0] OP_SCAN  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;

  // Pin levels of an active-low pull-up button
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/multi_button_debounce_click_latch.sv
// Debouncer and click latch for a bank of BUTTON_COUNT active-low buttons.
// A scan item (opcode 0) walks the buttons one per cycle through the
// change-timestamp RAM (one read and one write port, registered read).
// After the last button a finish state loads the result register and
// returns to idle. Query (opcode 1) and clear (opcode 2) items do not
// use the RAM and give their result the cycle after transfer, as does
// an unused opcode, with clicked low. One item is in work at a time; the
// result sits in an output register, and a new item is taken in the cycle
// that result is transferred.
// debounce_ms is written at any cycle with cfg_we high, and should only
// change while no item is in work.
// Every result carries the debounced pressed mask and pending click mask.
`default_nettype none

module multi_button_debounce_click_latch
  import mbdcl_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [DEBOUNCE_BITS-1:0] cfg_wdata,
  // input items
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OPCODE_BITS-1:0]   opcode,
  input  wire logic [PIN_BITS-1:0]      pin_levels,
  input  wire logic [TIME_BITS-1:0]     now_ms,
  input  wire logic [NUMBER_BITS-1:0]   btn_num,
  // result items
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          clicked,
  output logic [MASK_BITS-1:0]          pressed_mask,
  output logic [MASK_BITS-1:0]          pending_mask
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);
  localparam logic [5:0] COUNT_6 = 6'(BUTTON_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                    state;
  logic [DEBOUNCE_BITS-1:0]  debounce_ms;
  logic [PIN_BITS-1:0]       pins;
  logic [TIME_BITS-1:0]      now_r;
  logic [IDX_W-1:0]          idx;
  logic [BUTTON_COUNT-1:0]   last_level;
  logic [BUTTON_COUNT-1:0]   pressed_flag;
  logic [BUTTON_COUNT-1:0]   click_pending;
  logic [BUTTON_COUNT-1:0]   ct_valid;

  // change timestamp RAM
  logic [TIME_BITS-1:0]      ct_mem [BUTTON_COUNT];
  logic [TIME_BITS-1:0]      ct_q;
  logic                      ct_q_valid;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;

  logic                      accept;
  logic                      res_load;
  logic [BUTTON_COUNT-1:0]   lvl_vec;
  logic                      lvl;
  logic                      level_changed;
  logic [TIME_BITS-1:0]      base_time;
  logic [TIME_BITS-1:0]      eff_time;
  logic [TIME_BITS-1:0]      elapsed;
  logic                      settled;
  logic                      down;
  logic [4:0]                num_idx;
  logic                      num_ok;
  logic [BUTTON_COUNT-1:0]   pending_cleared;
  logic [MASK_BITS-1:0]      pressed_m;
  logic [MASK_BITS-1:0]      pending_m;
  logic [MASK_BITS-1:0]      pending_clr_m;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Load a result on a direct item or at the end of a scan
  assign res_load = (accept && (opcode != OP_SCAN)) || (state == ST_FINISH);

  // Buttons past the pin field read released
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lvl
    if (i < PIN_BITS) begin : g_pin
      assign lvl_vec[i] = pins[i];
    end else begin : g_none
      assign lvl_vec[i] = LEVEL_RELEASED;
    end
  end

  // Pack flags into the fixed-width masks
  for (genvar j = 0; j < MASK_BITS; j++) begin : g_mask
    if (j < BUTTON_COUNT) begin : g_live
      assign pressed_m[j]     = pressed_flag[j];
      assign pending_m[j]     = click_pending[j];
      assign pending_clr_m[j] = pending_cleared[j];
    end else begin : g_dead
      assign pressed_m[j]     = 1'b0;
      assign pending_m[j]     = 1'b0;
      assign pending_clr_m[j] = 1'b0;
    end
  end

  // Per-button debounce step on the entry read last cycle
  assign lvl           = lvl_vec[idx];
  assign level_changed = (lvl != last_level[idx]);
  assign base_time     = ct_q_valid ? ct_q : '0;
  assign eff_time      = level_changed ? now_r : base_time;
  assign elapsed       = now_r - eff_time;
  assign settled       = (elapsed > {{(TIME_BITS-DEBOUNCE_BITS){1'b0}}, debounce_ms});
  assign down          = (lvl == LEVEL_PRESSED);
  assign wr_en         = (state == ST_SCAN) && level_changed;

  // Read the next button while the current one is processed, else button 0
  assign rd_addr = ((state == ST_SCAN) && (idx != LAST_IDX)) ? IDX_W'(idx + 1'b1) : '0;

  // Button number check for query and clear
  assign num_idx = {1'b0, btn_num} - 5'd1;
  assign num_ok  = (btn_num != '0) && ({2'b00, btn_num} <= COUNT_6);

  always_comb begin
    pending_cleared = click_pending;
    if (num_ok) begin
      pending_cleared[num_idx[IDX_W-1:0]] = 1'b0;
    end
  end

  // Timestamp RAM: registered read, write on a level change
  always_ff @(posedge clk) begin
    ct_q <= ct_mem[rd_addr];
    if (wr_en) begin
      ct_mem[idx] <= now_r;
    end
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ct_valid   <= '0;
      ct_q_valid <= 1'b0;
    end else begin
      ct_q_valid <= ct_valid[rd_addr] || (wr_en && (idx == rd_addr));
      if (wr_en) begin
        ct_valid[idx] <= 1'b1;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ms <= cfg_wdata;
    end
  end

  // Sequencer, button flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      idx           <= '0;
      last_level    <= '1;
      pressed_flag  <= '0;
      click_pending <= '0;
    end else begin
      // Raise the result or drop it once transferred
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pins  <= pin_levels;
            now_r <= now_ms;
            idx   <= '0;
            unique case (opcode)
              OP_SCAN: begin
                state <= ST_SCAN;
              end
              OP_QUERY: begin
                clicked      <= num_ok && click_pending[num_idx[IDX_W-1:0]];
                pressed_mask <= pressed_m;
                pending_mask <= pending_m;
              end
              OP_CLEAR: begin
                click_pending <= pending_cleared;
                clicked       <= 1'b0;
                pressed_mask  <= pressed_m;
                pending_mask  <= pending_clr_m;
              end
              default: begin
                clicked      <= 1'b0;
                pressed_mask <= pressed_m;
                pending_mask <= pending_m;
              end
            endcase
          end
        end
        ST_SCAN: begin
          last_level[idx] <= lvl;
          if (settled) begin
            pressed_flag[idx] <= down;
            if (down && !pressed_flag[idx]) begin
              click_pending[idx] <= 1'b1;
            end
          end
          if (idx == LAST_IDX) begin
            state <= ST_FINISH;
          end else begin
            idx <= IDX_W'(idx + 1'b1);
          end
        end
        ST_FINISH: begin
          state        <= ST_IDLE;
          clicked      <= 1'b0;
          pressed_mask <= pressed_m;
          pending_mask <= pending_m;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mbdcl_checker.sv
`default_nettype none

module mbdcl_checker
  import mbdcl_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic [OPCODE_BITS-1:0]   opcode,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     clicked,
  input wire logic [MASK_BITS-1:0]     pressed_mask,
  input wire logic [MASK_BITS-1:0]     pending_mask
);

  localparam logic [MASK_BITS-1:0] LIVE_MASK =
    MASK_BITS'((64'd1 << BUTTON_COUNT) - 64'd1);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clicked) &&
      $stable(pressed_mask) && $stable(pending_mask))
    else $error("stalled result changed");

  // No new transfer while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken over a stalled result");

  // Drop the result after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Masks carry no buttons beyond the bank
  a_masks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pressed_mask & ~LIVE_MASK) == '0) &&
      ((pending_mask & ~LIVE_MASK) == '0))
    else $error("mask bit beyond button count");

  // Hold a waiting input item until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(opcode))
    else $error("waiting input item changed");

endmodule

bind multi_button_debounce_click_latch mbdcl_checker #(
  .BUTTON_COUNT(BUTTON_COUNT)
) u_mbdcl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .opcode       (opcode),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .clicked      (clicked),
  .pressed_mask (pressed_mask),
  .pending_mask (pending_mask)
);

`default_nettype wire

FILE: tb/tb_multi_button_debounce_click_latch.sv
`default_nettype none

module tb_multi_button_debounce_click_latch;
  import mbdcl_pkg::*;

  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int NBTN = BUTTON_COUNT_DEFAULT;
  localparam int SCAN_LATENCY = NBTN + 2;

  typedef struct packed {
    logic                 clicked;
    logic [MASK_BITS-1:0] pressed;
    logic [MASK_BITS-1:0] pending;
  } button_report_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [DEBOUNCE_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OPCODE_BITS-1:0]   opcode = '0;
  logic [PIN_BITS-1:0]      pin_levels = '1;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic [NUMBER_BITS-1:0]   btn_num = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     clicked;
  logic [MASK_BITS-1:0]     pressed_mask;
  logic [MASK_BITS-1:0]     pending_mask;

  // Predictor state: per-button level, change stamp, debounced and click flags
  logic [DEBOUNCE_BITS-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic                     pin_seen[NBTN];
  logic [TIME_BITS-1:0]     change_stamp[NBTN];
  logic                     is_down[NBTN];
  logic                     click_latched[NBTN];

  button_report_t report_q[$];
  int             mismatch_count = 0;
  bit             idle_on = 1'b1;

  multi_button_debounce_click_latch uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .pin_levels   (pin_levels),
    .now_ms       (now_ms),
    .btn_num      (btn_num),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clicked      (clicked),
    .pressed_mask (pressed_mask),
    .pending_mask (pending_mask)
  );

  initial begin
    for (int i = 0; i < NBTN; i++) begin
      pin_seen[i]      = LEVEL_RELEASED;
      change_stamp[i]  = '0;
      is_down[i]       = 1'b0;
      click_latched[i] = 1'b0;
    end
  end

  // Apply one item to the predictor and return the report it must produce
  function automatic button_report_t debounce_step(input logic [OPCODE_BITS-1:0] op,
                                                   input logic [PIN_BITS-1:0] lv,
                                                   input logic [TIME_BITS-1:0] now,
                                                   input logic [NUMBER_BITS-1:0] num);
    button_report_t r;
    logic [TIME_BITS-1:0] held_for;
    bit num_ok;
    r = '0;
    num_ok = (num >= 1) && (num <= NBTN);
    case (op)
      OP_SCAN: begin
        for (int i = 0; i < NBTN; i++) begin
          if (lv[i] != pin_seen[i]) change_stamp[i] = now;
          held_for = now - change_stamp[i];
          if (held_for > {16'd0, debounce_cfg}) begin
            if (lv[i] == LEVEL_PRESSED && !is_down[i]) click_latched[i] = 1'b1;
            is_down[i] = (lv[i] == LEVEL_PRESSED);
          end
          pin_seen[i] = lv[i];
        end
      end
      OP_QUERY: begin
        if (num_ok) r.clicked = click_latched[num - 1];
      end
      OP_CLEAR: begin
        if (num_ok) click_latched[num - 1] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < NBTN; i++) begin
      r.pressed[i] = is_down[i];
      r.pending[i] = click_latched[i];
    end
    return r;
  endfunction

  function automatic logic [NUMBER_BITS-1:0] pick_number();
    if ($urandom_range(0, 6) != 0) return NUMBER_BITS'($urandom_range(1, NBTN));
    return NUMBER_BITS'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // Send one item; call at a rising edge, returns at the edge of its transfer
  task automatic send_item(input logic [OPCODE_BITS-1:0] op, input logic [PIN_BITS-1:0] lv,
                           input logic [TIME_BITS-1:0] now,
                           input logic [NUMBER_BITS-1:0] num);
    bit took;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    pin_levels <= lv;
    now_ms     <= now;
    btn_num    <= num;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      @(posedge clk);
    end
    report_q.push_back(debounce_step(op, lv, now, num));
  endtask

  // Write the debounce register once the block has drained
  task automatic write_debounce(input logic [DEBOUNCE_BITS-1:0] v);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SCAN_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_cfg = v;
  endtask

  // Bad numbers, unused opcode, press and release at the debounce boundary
  task automatic test_reset_state();
    send_item(OP_QUERY, 10'h000, 32'h0000_0000, 4'd0);
    send_item(OP_QUERY, 10'h3FF, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_UNUSED, 10'h000, 32'hFFFF_FFFF, 4'd1);
    send_item(OP_SCAN, 10'h000, 32'd0, 4'd0);
    send_item(OP_SCAN, 10'h000, 32'd50, 4'd0);
    send_item(OP_SCAN, 10'h000, 32'd51, 4'd0);
    send_item(OP_QUERY, 10'h000, 32'd0, 4'd1);
    send_item(OP_QUERY, 10'h000, 32'd0, 4'd10);
    send_item(OP_QUERY, 10'h000, 32'd0, 4'd11);
    send_item(OP_CLEAR, 10'h000, 32'd0, 4'd3);
    send_item(OP_CLEAR, 10'h000, 32'd0, 4'd0);
    send_item(OP_CLEAR, 10'h000, 32'd0, 4'd12);
    send_item(OP_QUERY, 10'h000, 32'd0, 4'd3);
    send_item(OP_SCAN, 10'h3FF, 32'd60, 4'd0);
    send_item(OP_SCAN, 10'h3FF, 32'd111, 4'd0);
  endtask

  // Stable time measured across the 32-bit wrap of the tick counter
  task automatic test_timestamp_wrap();
    send_item(OP_SCAN, 10'h3FE, 32'hFFFF_FFF0, 4'd0);
    send_item(OP_SCAN, 10'h3FE, 32'h0000_0022, 4'd0);
    send_item(OP_SCAN, 10'h3FE, 32'h0000_0023, 4'd0);
  endtask

  // Smallest and largest debounce delay
  task automatic test_debounce_extremes();
    write_debounce(16'd0);
    send_item(OP_SCAN, 10'h155, 32'd1000, 4'd0);
    send_item(OP_SCAN, 10'h155, 32'd1001, 4'd0);
    write_debounce(16'hFFFF);
    send_item(OP_SCAN, 10'h2AA, 32'd5000, 4'd0);
    send_item(OP_SCAN, 10'h2AA, 32'd5000 + 32'd65535, 4'd0);
    send_item(OP_SCAN, 10'h2AA, 32'd5000 + 32'd65536, 4'd0);
  endtask

  // Random press sequences with bounce, queries, clears and noise
  task automatic test_random_mix(input logic [DEBOUNCE_BITS-1:0] dbc,
                                 input logic [TIME_BITS-1:0] t0, input int count,
                                 input bit idles);
    logic [TIME_BITS-1:0] tnow;
    logic [PIN_BITS-1:0]  held;
    logic [PIN_BITS-1:0]  sent;
    int r;
    int d;
    int k;
    write_debounce(dbc);
    tnow = t0;
    held = '1;
    for (int n = 0; n < count; n++) begin
      idle_on = idles && ((n / 80) % 3 != 2);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // move the held pattern now and then, bounce some scans
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 3)) held[$urandom_range(0, NBTN - 1)] ^= 1'b1;
        sent = held;
        if ($urandom_range(0, 9) < 2) sent ^= PIN_BITS'($urandom());
        k = $urandom_range(0, 19);
        if (k < 8) begin
          tnow += $urandom_range(0, 3);
        end else if (k < 16) begin
          d = int'(dbc) + int'($urandom_range(0, 4)) - 2;
          if (d < 0) d = 0;
          tnow += d;
        end else if (k < 19) begin
          tnow += $urandom_range(0, 2 * int'(dbc) + 10);
        end else begin
          tnow = $urandom();
        end
        send_item(OP_SCAN, sent, tnow, NUMBER_BITS'($urandom()));
      end else if (r < 80) begin
        send_item(OP_QUERY, PIN_BITS'($urandom()), $urandom(), pick_number());
      end else if (r < 95) begin
        send_item(OP_CLEAR, PIN_BITS'($urandom()), $urandom(), pick_number());
      end else begin
        send_item(OP_UNUSED, PIN_BITS'($urandom()), $urandom(), NUMBER_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // Stall the result side in random bursts
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (idle_on && !rst && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each transferred result with the oldest expected report
  initial begin : result_check
    button_report_t want;
    bit hs;
    logic c;
    logic [MASK_BITS-1:0] pm;
    logic [MASK_BITS-1:0] qm;
    forever begin
      @(negedge clk);
      hs = (out_valid === 1'b1) && (out_ready === 1'b1);
      c  = clicked;
      pm = pressed_mask;
      qm = pending_mask;
      @(posedge clk);
      if (hs) begin
        if (report_q.size() == 0) begin
          report_mismatch("unexpected result, pressed_mask", 32'h0, 32'(pm));
        end else begin
          want = report_q.pop_front();
          if (c !== want.clicked) report_mismatch("clicked", 32'(want.clicked), 32'(c));
          if (pm !== want.pressed)
            report_mismatch("pressed_mask", 32'(want.pressed), 32'(pm));
          if (qm !== want.pending)
            report_mismatch("pending_mask", 32'(want.pending), 32'(qm));
        end
      end
    end
  end

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_timestamp_wrap();
    test_debounce_extremes();
    test_random_mix(DEBOUNCE_BITS'($urandom_range(1, 40)), $urandom(), 300, 1'b1);
    test_random_mix(16'd0, $urandom(), 250, 1'b1);
    test_random_mix(16'hFFFF, 32'hFFFE_0000, 250, 1'b1);
    test_random_mix(DEBOUNCE_BITS'($urandom()), $urandom(), 300, 1'b1);
    test_random_mix(DEBOUNCE_RESET, $urandom(), 350, 1'b0);
    // drain outstanding results, then watch for strays
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (2 * SCAN_LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 800000);
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/mbdcl_pkg.sv
hdl/multi_button_debounce_click_latch.sv
hdl/mbdcl_checker.sv
tb/tb_multi_button_debounce_click_latch.sv
